>>> hw/rtl/snl_pkg.sv
// ----------------------------------------------------------------------------
// snl_pkg
// types, token codes and keyword tables shared by the lexer modules
// ----------------------------------------------------------------------------
package snl_pkg;

    // token kinds
    localparam logic [4:0] K_LBRACE    = 5'd0;
    localparam logic [4:0] K_RBRACE    = 5'd1;
    localparam logic [4:0] K_LPAREN    = 5'd2;
    localparam logic [4:0] K_RPAREN    = 5'd3;
    localparam logic [4:0] K_BACKSLASH = 5'd4;
    localparam logic [4:0] K_BAR       = 5'd5;
    localparam logic [4:0] K_COMMA     = 5'd6;
    localparam logic [4:0] K_CARET     = 5'd7;
    localparam logic [4:0] K_EQUAL     = 5'd8;
    localparam logic [4:0] K_NUM       = 5'd9;
    localparam logic [4:0] K_CHAR      = 5'd10;
    localparam logic [4:0] K_WORD      = 5'd11;
    localparam logic [4:0] K_NOT       = 5'd12;
    localparam logic [4:0] K_UNION     = 5'd13;
    localparam logic [4:0] K_INTERSECT = 5'd14;
    localparam logic [4:0] K_SUBSET    = 5'd15;
    localparam logic [4:0] K_OF        = 5'd16;
    localparam logic [4:0] K_END       = 5'd17;

    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [30:0] NUM_MAX  = 31'h7fff_ffff;

    localparam int          NUM_KW = 5;
    localparam logic [71:0] KW_STR  [NUM_KW] = '{"not", "union", "intersect", "subset", "of"};
    localparam logic [3:0]  KW_LEN  [NUM_KW] = '{4'd3, 4'd5, 4'd9, 4'd6, 4'd2};
    localparam logic [4:0]  KW_KIND [NUM_KW] = '{K_NOT, K_UNION, K_INTERSECT, K_SUBSET, K_OF};

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_NUM,
        CLS_WORD
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_WREAD,
        ST_WEMIT,
        ST_APPLY,
        ST_END
    } state_t;

    // clear / step control for the accumulator and keyword matcher
    typedef struct packed {
        logic clear;
        logic step;
    } upd_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        logic r;
        case (b)
            "{", "}", "(", ")", "\\", "|", ",", "^", "=": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "\\":    k = K_BACKSLASH;
            "|":     k = K_BAR;
            ",":     k = K_COMMA;
            "^":     k = K_CARET;
            "=":     k = K_EQUAL;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // character at position pos of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        int len;
        int p;
        len = int'(KW_LEN[k]);
        p   = int'(pos);
        if (p < len) begin
            return KW_STR[k][8 * (len - 1 - p) +: 8];
        end
        return 8'h00;
    endfunction

endpackage

>>> hw/rtl/snl_word_mem.sv
// ----------------------------------------------------------------------------
// snl_word_mem
// word character store, one write port and one registered read port
// ----------------------------------------------------------------------------
module snl_word_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/snl_num_acc.sv
// ----------------------------------------------------------------------------
// snl_num_acc
// decimal accumulator, value = value * 10 + digit, saturating
// ----------------------------------------------------------------------------
module snl_num_acc (
    input  logic         aclk,
    input  logic         aresetn,
    input  snl_pkg::upd_t ctl,
    input  logic [7:0]   digit_byte,
    output logic [30:0]  value,
    output logic [7:0]   last_digit
);
    import snl_pkg::*;

    logic [30:0] acc_reg, acc_next;
    logic [7:0]  last_reg, last_next;
    logic [34:0] prod;

    // times ten as two shifts and an add
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {31'b0, digit_byte[3:0]};

    always_comb begin
        acc_next  = acc_reg;
        last_next = last_reg;
        if (ctl.clear) begin
            acc_next  = '0;
            last_next = '0;
        end else if (ctl.step) begin
            acc_next  = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[30:0];
            last_next = digit_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            last_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            last_reg <= last_next;
        end
    end

    assign value      = acc_reg;
    assign last_digit = last_reg;

endmodule

>>> hw/rtl/snl_kw_match.sv
// ----------------------------------------------------------------------------
// snl_kw_match
// keyword matcher, checks each word character against all keywords as it
// is stored
// ----------------------------------------------------------------------------
module snl_kw_match #(
    parameter int LEN_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  snl_pkg::upd_t    ctl,
    input  logic [LEN_W-1:0] idx,
    input  logic [7:0]       ch,
    input  logic [LEN_W-1:0] len,
    output logic             hit,
    output logic [4:0]       hit_kind
);
    import snl_pkg::*;

    logic [NUM_KW-1:0] flags_reg, flags_next;

    always_comb begin
        flags_next = flags_reg;
        if (ctl.clear) begin
            flags_next = '1;
        end else if (ctl.step) begin
            for (int k = 0; k < NUM_KW; k++) begin
                flags_next[k] = flags_reg[k] && (idx < LEN_W'(KW_LEN[k]))
                              && (ch == kw_char(k, idx[3:0]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '1;
        end else begin
            flags_reg <= flags_next;
        end
    end

    // keyword lengths differ, so at most one can hit
    always_comb begin
        hit      = 1'b0;
        hit_kind = K_WORD;
        for (int k = 0; k < NUM_KW; k++) begin
            if (flags_reg[k] && (len == LEN_W'(KW_LEN[k]))) begin
                hit      = 1'b1;
                hit_kind = KW_KIND[k];
            end
        end
    end

endmodule

>>> hw/rtl/set_notation_lexer_unit.sv
// ----------------------------------------------------------------------------
// set_notation_lexer_unit
// byte-stream lexer for set notation: punctuation, numbers, characters,
// keywords and word runs, with an end token on the final byte
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                  | tlast
//  --------+-----+----------------------------------------+----------
//  s_      | in  | text_byte                              | is_final
//  m_      | out | token_kind, number_value, char_value,  | run_last
//          |     | word_char                              |
//
//  sequence: each byte is accepted while idle, then applied; a flush emits the
//  pending run, a word or char by reading, then emitting each stored character;
//  the final byte always runs a flush, then the end token is emitted
//  reset: synchronous, active low; the word store has no reset and needs
//  no clearing pass, only written entries are ever read
//  stalls: each result waits in the output register; s_tready is high only
//  while idle, so a stalled result holds up the next byte once the sequencer
//  needs the output register again
//
module set_notation_lexer_unit #(
    parameter int MAX_WORD = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] token_kind, [35:5] number_value,
                                   // [43:36] char_value, [51:44] word_char
    output logic        m_tlast
);
    import snl_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORD);
    localparam int LEN_W = $clog2(MAX_WORD + 2);

    // sequencer state
    state_t           state_reg, state_next;
    logic             post_reg, post_next;      // flush belongs to the final byte
    logic [7:0]       byte_reg, byte_next;
    logic             fin_reg, fin_next;
    cls_t             pend_reg, pend_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [55:0]      m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    // shared units
    upd_t             acc_ctl, kw_ctl;
    logic [30:0]      acc_value;
    logic [7:0]       acc_last;
    logic             kw_hit;
    logic [4:0]       kw_kind;
    logic             mem_we, mem_re;
    logic [7:0]       mem_rdata;

    logic             out_free;
    logic             s_digit, s_word, need_pre;
    logic             b_digit, b_punct, b_word;
    logic [LEN_W-1:0] stored_len;
    logic             run_end;
    logic             do_clear;
    logic             emit;
    logic [4:0]       e_kind;
    logic [30:0]      e_num;
    logic [7:0]       e_char, e_wchar;
    logic             e_last;

    assign out_free = !m_valid_reg || m_tready;

    // class of the byte on the input port
    assign s_digit  = is_digit(s_tdata);
    assign s_word   = !s_digit && !is_punct(s_tdata) && (s_tdata != CH_SPACE);
    // a pending run of the other class ends before this byte
    assign need_pre = (pend_reg != CLS_NONE)
                   && !(s_digit && (pend_reg == CLS_NUM))
                   && !(s_word && (pend_reg == CLS_WORD));

    // class of the latched byte
    assign b_digit  = is_digit(byte_reg);
    assign b_punct  = is_punct(byte_reg);
    assign b_word   = !b_digit && !b_punct && (byte_reg != CH_SPACE);

    // overflowed words are sent as their first MAX_WORD characters
    assign stored_len = (len_reg > LEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD) : len_reg;
    assign run_end    = LEN_W'(idx_reg + 1'b1) == stored_len;

    always_comb begin
        state_next = state_reg;
        post_next  = post_reg;
        byte_next  = byte_reg;
        fin_next   = fin_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        acc_ctl    = '0;
        kw_ctl     = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        do_clear   = 1'b0;
        emit       = 1'b0;
        e_kind     = K_END;
        e_num      = '0;
        e_char     = '0;
        e_wchar    = '0;
        e_last     = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    byte_next  = s_tdata;
                    fin_next   = s_tlast;
                    post_next  = 1'b0;
                    state_next = need_pre ? ST_FLUSH : ST_APPLY;
                end
            end

            ST_FLUSH: begin
                case (pend_reg)
                    CLS_NUM: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_kind   = K_NUM;
                            e_num    = acc_value;
                            e_char   = acc_last;
                            do_clear = 1'b1;
                        end
                    end
                    CLS_WORD: begin
                        if (kw_hit) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_kind   = kw_kind;
                                do_clear = 1'b1;
                            end
                        end else begin
                            idx_next   = '0;
                            state_next = ST_WREAD;
                        end
                    end
                    default: begin
                        do_clear = 1'b1;
                    end
                endcase
            end

            ST_WREAD: begin
                mem_re     = 1'b1;
                state_next = ST_WEMIT;
            end

            ST_WEMIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = run_end;
                    // a one-character word is a char token
                    if (len_reg == LEN_W'(1)) begin
                        e_kind = K_CHAR;
                        e_char = mem_rdata;
                    end else begin
                        e_kind  = K_WORD;
                        e_wchar = mem_rdata;
                    end
                    if (run_end) begin
                        do_clear = 1'b1;
                    end else begin
                        idx_next   = LEN_W'(idx_reg + 1'b1);
                        state_next = ST_WREAD;
                    end
                end
            end

            ST_APPLY: begin
                if (!b_punct || out_free) begin
                    if (b_digit) begin
                        acc_ctl.step = 1'b1;
                        pend_next    = CLS_NUM;
                    end else if (b_punct) begin
                        emit   = 1'b1;
                        e_kind = punct_kind(byte_reg);
                        e_char = byte_reg;
                    end else if (b_word) begin
                        kw_ctl.step = 1'b1;
                        pend_next   = CLS_WORD;
                        mem_we      = len_reg < LEN_W'(MAX_WORD);
                        if (len_reg <= LEN_W'(MAX_WORD)) begin
                            len_next = LEN_W'(len_reg + 1'b1);
                        end
                    end
                    if (fin_reg) begin
                        post_next  = 1'b1;
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_END: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = K_END;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // end of a flush: back to reset values, then on to the byte or the end
        if (do_clear) begin
            acc_ctl.clear = 1'b1;
            kw_ctl.clear  = 1'b1;
            pend_next     = CLS_NONE;
            len_next      = '0;
            state_next    = post_reg ? ST_END : ST_APPLY;
        end
    end

    // output register load
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, e_wchar, e_char, e_num, e_kind};
            m_last_next  = e_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            post_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            pend_reg    <= CLS_NONE;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            post_reg    <= post_next;
            fin_reg     <= fin_next;
            pend_reg    <= pend_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    snl_num_acc u_num_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (acc_ctl),
        .digit_byte (byte_reg),
        .value      (acc_value),
        .last_digit (acc_last)
    );

    snl_kw_match #(
        .LEN_W (LEN_W)
    ) u_kw_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (kw_ctl),
        .idx      (len_reg),
        .ch       (byte_reg),
        .len      (len_reg),
        .hit      (kw_hit),
        .hit_kind (kw_kind)
    );

    snl_word_mem #(
        .DEPTH  (MAX_WORD),
        .ADDR_W (IDX_W)
    ) u_word_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (len_reg[IDX_W-1:0]),
        .wr_data (byte_reg),
        .rd_en   (mem_re),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // word length never runs past the overflow mark
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_WORD + 1))
        else $error("word length past overflow mark");

    // with nothing pending the word length and the number accumulator are cleared
    a_none_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == CLS_NONE) |-> (len_reg == '0) && (acc_value == '0))
        else $error("state not cleared with nothing pending");

    // word emission only runs on a pending word
    a_wemit_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WREAD) |=> (state_reg == ST_WEMIT) && (pend_reg == CLS_WORD))
        else $error("word read without a pending word");

endmodule
